/* rtl/srdz_pkg.sv */
package srdz_pkg;

   localparam int AXIS_BITS = 16;
   localparam int DZ_W      = AXIS_BITS - 1;
   localparam int OUT_W     = AXIS_BITS;
   localparam int MAG_W     = 2 * AXIS_BITS - 2;
   localparam int SQ_W      = 2 * MAG_W + 1;
   localparam int ROOT_W    = MAG_W + 1;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int Q_BITS    = 30;
   localparam int QUO_W     = Q_BITS + 1;
   localparam int DIV_W     = ROOT_W;
   localparam int NUM_W     = MAG_W + QUO_W;
   localparam int SC_W      = QUO_W + AXIS_BITS - 1;

   localparam longint FS_NEG_V = longint'(1) << (AXIS_BITS - 1);
   localparam longint FS_POS_V = FS_NEG_V - 1;

   localparam logic [MAG_W-1:0]   FS_NEG_M = MAG_W'(FS_NEG_V);
   localparam logic [MAG_W-1:0]   FS_POS_M = MAG_W'(FS_POS_V);
   localparam logic [MAG_W-1:0]   D_FULL   = MAG_W'(FS_POS_V * FS_NEG_V);
   localparam logic [2*MAG_W-1:0] D_SQ     =
      (2*MAG_W)'((FS_POS_V * FS_NEG_V) * (FS_POS_V * FS_NEG_V));
   localparam logic [SC_W-1:0]    FSP_SC   = SC_W'(FS_POS_V);
   localparam logic [OUT_W-1:0]   OUT_MAX  = OUT_W'(FS_POS_V);
   localparam logic [QUO_W-1:0]   MQ_ONE   = QUO_W'(1) << Q_BITS;
   localparam logic [DZ_W-1:0]    DZ_RESET = DZ_W'(7849);

   // pipeline levels
   localparam int LVL_SQ = 4;
   localparam int LVL_P  = LVL_SQ + ROOT_W;
   localparam int LVL_D1 = LVL_P + 1;
   localparam int LVL_M  = LVL_D1 + QUO_W;
   localparam int LVL_D2 = LVL_M + 1;
   localparam int N_LVL  = LVL_D2 + QUO_W;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [ROOT_W:0]   rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [QUO_W-1:0] num;
      logic [QUO_W-1:0] quo;
      logic [DIV_W-1:0] dvs;
   } div_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag_x;
      logic [MAG_W-1:0] mag_y;
      logic             neg_x;
      logic             neg_y;
      logic             dead;
      logic             big;
   } sq_side_type;

   typedef struct packed {
      logic [ROOT_W-1:0] root;
      logic [MAG_W-1:0]  mag_x;
      logic [MAG_W-1:0]  mag_y;
      logic              neg_x;
      logic              neg_y;
      logic              dead;
      logic              kill;
   } d1_side_type;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic dead;
      logic kill;
   } d2_side_type;

endpackage

/* rtl/srdz_sqrt_cell.sv */
module srdz_sqrt_cell import srdz_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  sqrt_type src,
   output sqrt_type dst
);

   logic [ROOT_W+2:0] t;
   logic [ROOT_W+2:0] trial;
   logic [ROOT_W+2:0] diff;
   logic              ge;
   sqrt_type          stage_in;
   sqrt_type          stage_ff;

   always_comb begin
      t     = {src.rem, src.rad[RAD_W-1 -: 2]};
      trial = (ROOT_W+3)'({src.root, 2'b01});
      diff  = t - trial;
      ge    = (t >= trial);
      stage_in.rad  = {src.rad[RAD_W-3:0], 2'b00};
      stage_in.rem  = ge ? diff[ROOT_W:0] : t[ROOT_W:0];
      stage_in.root = {src.root[ROOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign dst = stage_ff;

endmodule

/* rtl/srdz_div_cell.sv */
module srdz_div_cell import srdz_pkg::*; (
   input  logic    clock,
   input  logic    en,
   input  div_type src,
   output div_type dst
);

   logic [DIV_W:0] t;
   logic [DIV_W:0] diff;
   logic           ge;
   div_type        stage_in;
   div_type        stage_ff;

   always_comb begin
      t    = {src.rem, src.num[QUO_W-1]};
      diff = t - {1'b0, src.dvs};
      ge   = (t >= {1'b0, src.dvs});
      stage_in.rem = ge ? diff[DIV_W-1:0] : t[DIV_W-1:0];
      stage_in.num = {src.num[QUO_W-2:0], 1'b0};
      stage_in.quo = {src.quo[QUO_W-2:0], ge};
      stage_in.dvs = src.dvs;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign dst = stage_ff;

endmodule

/* rtl/stick_radial_dead_zone.sv */
// Scaled radial dead zone for one two-axis stick. Each request carries a raw
// signed sample pair and a connected flag; each produces exactly one response
// with the conditioned vector scaled by 32767 and a dead zone flag. The block
// is a pipeline that takes one request every cycle while not stalled: a row
// of 31 square root cells, then a row of 31 divider cells for the magnitude,
// then two rows of 31 divider cells for the axes. When a response waits
// unaccepted the whole pipeline holds and req_stall is raised. The dead zone
// register is written through csr_wr_en and csr_wr_data and should be changed
// only with the pipeline empty.
module stick_radial_dead_zone import srdz_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [OUT_W-1:0] req_raw_x,
   input  logic signed [OUT_W-1:0] req_raw_y,
   input  logic                    req_connected,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_out_x,
   output logic signed [OUT_W-1:0] rsp_out_y,
   output logic                    rsp_in_dead_zone,
   input  logic                    csr_wr_en,
   input  logic [DZ_W-1:0]         csr_wr_data
);

   function automatic logic [OUT_W-1:0] out_comp(input logic [QUO_W-1:0] u,
                                                 input logic neg,
                                                 input logic zero);
      logic [SC_W-1:0]  sc;
      logic [OUT_W-1:0] o;
      sc = SC_W'(u) * FSP_SC;
      o  = sc[SC_W-1:Q_BITS];
      if (o > OUT_MAX) o = OUT_MAX;
      if (neg) o = -o;
      if (zero) o = '0;
      return o;
   endfunction

   logic             en;
   logic [DZ_W-1:0]  dz_ff;
   logic [N_LVL-1:0] vld_ff;
   logic             rsp_valid_ff;
   logic [OUT_W-1:0] rsp_out_x_ff;
   logic [OUT_W-1:0] rsp_out_y_ff;
   logic             rsp_in_dead_zone_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff <= DZ_RESET;
      end else if (csr_wr_en) begin
         dz_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[N_LVL-2:0], req_valid};
         rsp_valid_ff <= vld_ff[N_LVL-1];
      end
   end

   // front end: normalise, square, dead zone test
   logic signed [OUT_W-1:0] raw_x_ff;
   logic signed [OUT_W-1:0] raw_y_ff;
   logic                    conn_ff;
   logic [OUT_W-1:0]        abs_x;
   logic [OUT_W-1:0]        abs_y;
   logic [MAG_W-1:0]        mag_x_in;
   logic [MAG_W-1:0]        mag_y_in;
   logic [MAG_W-1:0]        mag_x_ff;
   logic [MAG_W-1:0]        mag_y_ff;
   logic                    neg_x_ff;
   logic                    neg_y_ff;
   logic                    conn1_ff;
   logic [2*MAG_W-1:0]      sq_x_ff;
   logic [2*MAG_W-1:0]      sq_y_ff;
   logic [2*DZ_W-1:0]       dzsq_ff;
   logic [MAG_W-1:0]        mag_x2_ff;
   logic [MAG_W-1:0]        mag_y2_ff;
   logic                    neg_x2_ff;
   logic                    neg_y2_ff;
   logic                    conn2_ff;
   logic [SQ_W-1:0]         s_sum;
   logic [SQ_W-1:0]         zsq_cmp;
   logic [RAD_W-1:0]        rad_ff;
   sq_side_type             side3_ff;

   always_comb begin
      abs_x    = raw_x_ff[OUT_W-1] ? OUT_W'(-raw_x_ff) : OUT_W'(raw_x_ff);
      abs_y    = raw_y_ff[OUT_W-1] ? OUT_W'(-raw_y_ff) : OUT_W'(raw_y_ff);
      mag_x_in = MAG_W'(abs_x) * (raw_x_ff[OUT_W-1] ? FS_POS_M : FS_NEG_M);
      mag_y_in = MAG_W'(abs_y) * (raw_y_ff[OUT_W-1] ? FS_POS_M : FS_NEG_M);
      s_sum    = SQ_W'(sq_x_ff) + SQ_W'(sq_y_ff);
      zsq_cmp  = SQ_W'({dzsq_ff, {(2*(AXIS_BITS-1)){1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         raw_x_ff  <= req_raw_x;
         raw_y_ff  <= req_raw_y;
         conn_ff   <= req_connected;
         mag_x_ff  <= mag_x_in;
         mag_y_ff  <= mag_y_in;
         neg_x_ff  <= raw_x_ff[OUT_W-1];
         neg_y_ff  <= raw_y_ff[OUT_W-1];
         conn1_ff  <= conn_ff;
         sq_x_ff   <= (2*MAG_W)'(mag_x_ff) * (2*MAG_W)'(mag_x_ff);
         sq_y_ff   <= (2*MAG_W)'(mag_y_ff) * (2*MAG_W)'(mag_y_ff);
         dzsq_ff   <= (2*DZ_W)'(dz_ff) * (2*DZ_W)'(dz_ff);
         mag_x2_ff <= mag_x_ff;
         mag_y2_ff <= mag_y_ff;
         neg_x2_ff <= neg_x_ff;
         neg_y2_ff <= neg_y_ff;
         conn2_ff  <= conn1_ff;
         rad_ff    <= RAD_W'(s_sum);
         side3_ff  <= '{mag_x: mag_x2_ff, mag_y: mag_y2_ff,
                        neg_x: neg_x2_ff, neg_y: neg_y2_ff,
                        dead: !conn2_ff || (s_sum <= zsq_cmp),
                        big: s_sum >= SQ_W'(D_SQ)};
      end
   end

   // square root row
   sqrt_type    sq_link [ROOT_W+1];
   sq_side_type sq_sd_ff [ROOT_W];

   assign sq_link[0] = '{rad: rad_ff, rem: '0, root: '0};

   for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
      srdz_sqrt_cell u_cell (
         .clock (clock),
         .en    (en),
         .src   (sq_link[g]),
         .dst   (sq_link[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_sd_ff[0] <= side3_ff;
         for (int i = 1; i < ROOT_W; i++) begin
            sq_sd_ff[i] <= sq_sd_ff[i-1];
         end
      end
   end

   // length clamp and magnitude numerator
   logic [ROOT_W-1:0] root_r;
   sq_side_type       sdp;
   logic [MAG_W-1:0]  z_val;
   logic [ROOT_W-1:0] z_ext;
   logic [ROOT_W-1:0] lc;
   logic [ROOT_W-1:0] diff_lz;
   logic              kill_p;
   logic [NUM_W-1:0]  num_p_ff;
   logic [DIV_W-1:0]  dvs_p_ff;
   d1_side_type       d1side_ff;

   always_comb begin
      root_r  = sq_link[ROOT_W].root;
      sdp     = sq_sd_ff[ROOT_W-1];
      z_val   = {dz_ff, {(AXIS_BITS-1){1'b0}}};
      z_ext   = ROOT_W'(z_val);
      lc      = sdp.big ? ROOT_W'(D_FULL) : root_r;
      diff_lz = lc - z_ext;
      kill_p  = (z_val >= D_FULL) || (root_r == '0) || (lc <= z_ext);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_p_ff  <= NUM_W'({diff_lz[MAG_W-1:0], {Q_BITS{1'b0}}});
         dvs_p_ff  <= DIV_W'(D_FULL - z_val);
         d1side_ff <= '{root: root_r, mag_x: sdp.mag_x, mag_y: sdp.mag_y,
                        neg_x: sdp.neg_x, neg_y: sdp.neg_y,
                        dead: sdp.dead, kill: kill_p};
      end
   end

   // magnitude divider row
   div_type     d1_link [QUO_W+1];
   d1_side_type d1_sd_ff [QUO_W];

   assign d1_link[0] = '{rem: DIV_W'(num_p_ff[NUM_W-1:QUO_W]),
                         num: num_p_ff[QUO_W-1:0], quo: '0, dvs: dvs_p_ff};

   for (genvar g = 0; g < QUO_W; g++) begin : g_div_mag
      srdz_div_cell u_cell (
         .clock (clock),
         .en    (en),
         .src   (d1_link[g]),
         .dst   (d1_link[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_sd_ff[0] <= d1side_ff;
         for (int i = 1; i < QUO_W; i++) begin
            d1_sd_ff[i] <= d1_sd_ff[i-1];
         end
      end
   end

   // direction times magnitude
   logic [QUO_W-1:0]  mq;
   d1_side_type       sm;
   logic [NUM_W-1:0]  prod_x_ff;
   logic [NUM_W-1:0]  prod_y_ff;
   logic [ROOT_W-1:0] root_m_ff;
   d2_side_type       d2side_ff;

   assign mq = d1_link[QUO_W].quo;
   assign sm = d1_sd_ff[QUO_W-1];

   always_ff @(posedge clock) begin
      if (en) begin
         prod_x_ff <= NUM_W'(sm.mag_x) * NUM_W'(mq);
         prod_y_ff <= NUM_W'(sm.mag_y) * NUM_W'(mq);
         root_m_ff <= sm.root;
         d2side_ff <= '{neg_x: sm.neg_x, neg_y: sm.neg_y,
                        dead: sm.dead, kill: sm.kill};
      end
   end

   // per axis divider rows
   div_type     dx_link [QUO_W+1];
   div_type     dy_link [QUO_W+1];
   d2_side_type d2_sd_ff [QUO_W];
   d2_side_type so;

   assign dx_link[0] = '{rem: DIV_W'(prod_x_ff[NUM_W-1:QUO_W]),
                         num: prod_x_ff[QUO_W-1:0], quo: '0, dvs: root_m_ff};
   assign dy_link[0] = '{rem: DIV_W'(prod_y_ff[NUM_W-1:QUO_W]),
                         num: prod_y_ff[QUO_W-1:0], quo: '0, dvs: root_m_ff};

   for (genvar g = 0; g < QUO_W; g++) begin : g_div_axis
      srdz_div_cell u_cell_x (
         .clock (clock),
         .en    (en),
         .src   (dx_link[g]),
         .dst   (dx_link[g+1])
      );
      srdz_div_cell u_cell_y (
         .clock (clock),
         .en    (en),
         .src   (dy_link[g]),
         .dst   (dy_link[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_sd_ff[0] <= d2side_ff;
         for (int i = 1; i < QUO_W; i++) begin
            d2_sd_ff[i] <= d2_sd_ff[i-1];
         end
      end
   end

   assign so = d2_sd_ff[QUO_W-1];

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_out_x_ff        <= out_comp(dx_link[QUO_W].quo, so.neg_x,
                                         so.dead || so.kill);
         rsp_out_y_ff        <= out_comp(dy_link[QUO_W].quo, so.neg_y,
                                         so.dead || so.kill);
         rsp_in_dead_zone_ff <= so.dead;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = rsp_out_x_ff;
   assign rsp_out_y        = rsp_out_y_ff;
   assign rsp_in_dead_zone = rsp_in_dead_zone_ff;

   a_dead_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_in_dead_zone_ff |-> rsp_out_x_ff == '0 && rsp_out_y_ff == '0)
      else $error("dead zone response not zero");

   a_sym_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_out_x_ff != {1'b1, {(OUT_W-1){1'b0}}} &&
                       rsp_out_y_ff != {1'b1, {(OUT_W-1){1'b0}}})
      else $error("response outside symmetric range");

   a_root_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LVL_P-1] && !sdp.big |-> root_r < ROOT_W'(D_FULL))
      else $error("unclamped length beyond full scale");

   a_mag_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LVL_M-1] && !sm.kill |-> mq <= MQ_ONE)
      else $error("magnitude above one");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(vld_ff))
      else $error("pipeline moved while response held");

endmodule
